@@ src/skrt_pkg.sv @@
// ----------------------------------------------------------------------------
// skrt_pkg
// Shared types and constants of the sorted key record table: operation and
// status codes, record layout, stream packing and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package skrt_pkg;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int AGE_W    = 8;
    localparam int NAME_W   = 16;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // Stored record: key in the low bits, then age, then name handle
    localparam int REC_KEY_LSB  = 0;
    localparam int REC_AGE_LSB  = REC_KEY_LSB + KEY_W;
    localparam int REC_NAME_LSB = REC_AGE_LSB + AGE_W;
    localparam int REC_W        = REC_NAME_LSB + NAME_W;

    // Input stream tdata: key, new_key, age, name_handle
    localparam int IN_KEY_LSB  = 0;
    localparam int IN_NKEY_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_AGE_LSB  = IN_NKEY_LSB + KEY_W;
    localparam int IN_NAME_LSB = IN_AGE_LSB + AGE_W;
    localparam int IN_TDATA_W  = IN_NAME_LSB + NAME_W;

    // Output stream tdata: status, position, entry_count, is_full, is_empty
    localparam int OUT_FIELDS_W = STATUS_W + POS_W + COUNT_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CHANGE = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    scan_run;
        logic    up_run;
        logic    dn_run;
        logic    put_new;
        logic    put_key;
        logic    drop_one;
        logic    set_status;
        status_t status_code;
        logic    zero_pos;
        logic    res_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    hit;
        logic    scan_end;
        logic    up_done;
        logic    dn_done;
    } dp_stat_t;

endpackage

@@ src/skrt_ram.sv @@
// ----------------------------------------------------------------------------
// skrt_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module skrt_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/skrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skrt_ctrl
// Controller of the record table: sequences decode, key scan, shift and
// write phases of one request and hands the result to the output register.
// ----------------------------------------------------------------------------
module skrt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  skrt_pkg::dp_stat_t   stat,
    output skrt_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_SHIFT_UP = 7'b0001000,
        S_SHIFT_DN = 7'b0010000,
        S_PUT_KEY  = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    skrt_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = skrt_pkg::ST_FULL;
                            cmd.zero_pos    = 1'b1;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    skrt_pkg::OP_DELETE, skrt_pkg::OP_CHANGE:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = skrt_pkg::ST_DONE;
                        cmd.zero_pos    = 1'b1;
                        state_next      = S_RESULT;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.hit)
                begin
                    case (stat.op)
                        skrt_pkg::OP_INSERT: state_next = S_SHIFT_UP;
                        skrt_pkg::OP_DELETE: state_next = S_SHIFT_DN;
                        skrt_pkg::OP_CHANGE: state_next = S_PUT_KEY;
                        default:             state_next = S_RESULT;
                    endcase
                end
                else if (stat.scan_end)
                begin
                    if (stat.op == skrt_pkg::OP_INSERT)
                    begin
                        state_next = S_SHIFT_UP;
                    end
                    else
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = skrt_pkg::ST_MISS;
                        cmd.zero_pos    = 1'b1;
                        state_next      = S_RESULT;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                cmd.up_run = 1'b1;
                if (stat.up_done)
                begin
                    cmd.put_new     = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = skrt_pkg::ST_DONE;
                    state_next      = S_RESULT;
                end
            end
            S_SHIFT_DN:
            begin
                cmd.dn_run = 1'b1;
                if (stat.dn_done)
                begin
                    cmd.drop_one    = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = skrt_pkg::ST_DONE;
                    state_next      = S_RESULT;
                end
            end
            S_PUT_KEY:
            begin
                cmd.put_key     = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = skrt_pkg::ST_DONE;
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ src/skrt_dp.sv @@
// ----------------------------------------------------------------------------
// skrt_dp
// Datapath of the record table: request registers, entry count, scan and
// shift pointers, the record RAM and the result register.
// ----------------------------------------------------------------------------
module skrt_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [skrt_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [skrt_pkg::OPCODE_W-1:0]       s_tuser,
    output logic [skrt_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  skrt_pkg::ctrl_cmd_t                 cmd,
    output skrt_pkg::dp_stat_t                  stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Request registers
    skrt_pkg::opcode_t            op_reg,    op_next;
    skrt_pkg::key_t               key_reg,   key_next;
    skrt_pkg::key_t               nkey_reg,  nkey_next;
    logic [skrt_pkg::AGE_W-1:0]   age_reg,   age_next;
    logic [skrt_pkg::NAME_W-1:0]  name_reg,  name_next;

    // Control registers
    logic [CW-1:0] count_reg,     count_next;
    logic [CW-1:0] rd_ptr_reg,    rd_ptr_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          wr_pend_reg,   wr_pend_next;

    // Working payload registers
    logic [CW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]               pos_reg,     pos_next;
    logic [AW-1:0]               wr_addr_reg, wr_addr_next;
    logic [skrt_pkg::REC_W-1:0]  hit_rec_reg, hit_rec_next;
    skrt_pkg::status_t           status_reg,  status_next;

    // Result register
    skrt_pkg::status_t           res_status_reg, res_status_next;
    logic [skrt_pkg::POS_W-1:0]  res_pos_reg,    res_pos_next;
    logic [skrt_pkg::COUNT_W-1:0] res_count_reg, res_count_next;
    logic                        res_full_reg,   res_full_next;
    logic                        res_empty_reg,  res_empty_next;

    // RAM ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [skrt_pkg::REC_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [skrt_pkg::REC_W-1:0]  ram_rdata;

    skrt_pkg::key_t rec_key;
    logic           cmp_match;
    logic           scan_more;
    logic           up_more;
    logic [CW-1:0]  rd_ptr_dec;
    logic [CW-1:0]  rd_ptr_inc;
    logic [CW-1:0]  cmp_idx_inc;

    skrt_ram #(
        .WIDTH (skrt_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare the entry read last cycle with the request key
    assign rec_key   = ram_rdata[skrt_pkg::REC_KEY_LSB +: skrt_pkg::KEY_W];
    assign cmp_match = (op_reg == skrt_pkg::OP_INSERT) ? !(key_reg > rec_key)
                                                       : (key_reg == rec_key);
    assign scan_more = rd_ptr_reg < count_reg;
    assign up_more   = rd_ptr_reg > pos_reg;
    assign rd_ptr_dec  = rd_ptr_reg - CW'(1);
    assign rd_ptr_inc  = rd_ptr_reg + CW'(1);
    assign cmp_idx_inc = cmp_idx_reg + CW'(1);

    // Status towards the controller
    always_comb
    begin
        stat.op       = op_reg;
        stat.full     = (count_reg == CAP_C);
        stat.hit      = cmp_valid_reg && cmp_match;
        stat.scan_end = !cmp_valid_reg && !scan_more;
        stat.up_done  = !up_more && !wr_pend_reg;
        stat.dn_done  = !scan_more && !wr_pend_reg;
    end

    // Read port: scan forwards, shift up reads downwards, shift down upwards
    always_comb
    begin
        ram_re    = (cmd.scan_run && scan_more) || (cmd.up_run && up_more) ||
                    (cmd.dn_run && scan_more);
        ram_raddr = cmd.up_run ? rd_ptr_dec[AW-1:0] : rd_ptr_reg[AW-1:0];
    end

    // Write port: pending shift move, new record, or changed key
    always_comb
    begin
        ram_we    = wr_pend_reg || cmd.put_new || cmd.put_key;
        ram_waddr = pos_reg[AW-1:0];
        ram_wdata = {name_reg, age_reg, key_reg};
        if (wr_pend_reg)
        begin
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.put_key)
        begin
            ram_wdata = {hit_rec_reg[skrt_pkg::REC_W-1:skrt_pkg::REC_AGE_LSB], nkey_reg};
        end
    end

    // Next values of the datapath registers
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        nkey_next       = nkey_reg;
        age_next        = age_reg;
        name_next       = name_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        cmp_valid_next  = 1'b0;
        wr_pend_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        pos_next        = pos_reg;
        wr_addr_next    = wr_addr_reg;
        hit_rec_next    = hit_rec_reg;
        status_next     = status_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_count_next  = res_count_reg;
        res_full_next   = res_full_reg;
        res_empty_next  = res_empty_reg;

        // Capture the request
        if (cmd.load)
        begin
            op_next   = skrt_pkg::opcode_t'(s_tuser);
            key_next  = s_tdata[skrt_pkg::IN_KEY_LSB  +: skrt_pkg::KEY_W];
            nkey_next = s_tdata[skrt_pkg::IN_NKEY_LSB +: skrt_pkg::KEY_W];
            age_next  = s_tdata[skrt_pkg::IN_AGE_LSB  +: skrt_pkg::AGE_W];
            name_next = s_tdata[skrt_pkg::IN_NAME_LSB +: skrt_pkg::NAME_W];
        end

        if (cmd.scan_init)
        begin
            rd_ptr_next = '0;
        end

        // Scan: one read issued per cycle, compared in the next cycle
        if (cmd.scan_run)
        begin
            if (scan_more)
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_ptr_reg;
                rd_ptr_next    = rd_ptr_inc;
            end
            if (stat.hit)
            begin
                pos_next     = cmp_idx_reg;
                hit_rec_next = ram_rdata;
                rd_ptr_next  = (op_reg == skrt_pkg::OP_INSERT) ? count_reg : cmp_idx_inc;
            end
            else if (stat.scan_end)
            begin
                pos_next    = count_reg;
                rd_ptr_next = count_reg;
            end
        end

        // Shift up: read entry i-1, write it to i next cycle
        if (cmd.up_run && up_more)
        begin
            wr_pend_next = 1'b1;
            wr_addr_next = rd_ptr_reg[AW-1:0];
            rd_ptr_next  = rd_ptr_dec;
        end

        // Shift down: read entry i, write it to i-1 next cycle
        if (cmd.dn_run && scan_more)
        begin
            wr_pend_next = 1'b1;
            wr_addr_next = rd_ptr_dec[AW-1:0];
            rd_ptr_next  = rd_ptr_inc;
        end

        if (cmd.put_new)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.drop_one)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.set_status)
        begin
            status_next = cmd.status_code;
            if (cmd.zero_pos)
            begin
                pos_next = '0;
            end
        end

        // Load the result register
        if (cmd.res_load)
        begin
            res_status_next = status_reg;
            res_pos_next    = skrt_pkg::POS_W'(pos_reg);
            res_count_next  = skrt_pkg::COUNT_W'(count_reg);
            res_full_next   = (count_reg == CAP_C);
            res_empty_next  = (count_reg == '0);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        nkey_reg       <= nkey_next;
        age_reg        <= age_next;
        name_reg       <= name_next;
        cmp_idx_reg    <= cmp_idx_next;
        pos_reg        <= pos_next;
        wr_addr_reg    <= wr_addr_next;
        hit_rec_reg    <= hit_rec_next;
        status_reg     <= status_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_count_reg  <= res_count_next;
        res_full_reg   <= res_full_next;
        res_empty_reg  <= res_empty_next;
    end

    assign m_tdata = {{skrt_pkg::OUT_PAD_W{1'b0}}, res_empty_reg, res_full_reg,
                      res_count_reg, res_pos_reg, res_status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count beyond capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_new |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance entry count");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("read and write at the same RAM address");

    a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(cmd.up_run || cmd.dn_run))
        else $error("shift write without a shift read");
`endif

endmodule

@@ src/sorted_key_record_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_key_record_table_unit
// Table of up to CAPACITY records (signed key, age, name handle) kept in
// ascending key order. Each request is insert (0), delete by key (1) or
// change key (2), given in s_tuser; code 3 does nothing. Insert goes before
// the first entry whose key is equal or larger and fails with status 1 when
// the table is full; delete and change act on the first entry with an equal
// key and report status 2 when none is found. Change overwrites the key in
// place and does not re-sort. Each request gives one result with status,
// position, entry count and full/empty flags. Requests are handled one at a
// time through a single record RAM that serves one read and one write a
// cycle: an insert or delete scans up to the matching entry, then shifts
// the rest by one. A new request is taken while the previous result still
// waits in the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_key_record_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: key[31:0], new_key[63:32], age[71:64], name_handle[87:72]
    input  logic [skrt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: opcode[1:0]
    input  logic [skrt_pkg::OPCODE_W-1:0]     s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: status[1:0], position[7:2], entry_count[14:8], is_full[15],
    //        is_empty[16], zero fill[23:17]
    output logic [skrt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    skrt_pkg::ctrl_cmd_t cmd;
    skrt_pkg::dp_stat_t  stat;

    // Sequence the phases of each request
    skrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the records, pointers and result
    skrt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
